[design/pdc_pkg.sv]
// Shared types and constants for the PID drive controller.
// Depends on nothing; used by the controller, datapath, divider and top level.
package pdc_pkg;

    localparam int GAIN_W   = 24;
    localparam int DATA_W   = 32;
    localparam int SUM_W    = 48;
    localparam int PROD_W   = 49;
    localparam int ACC_W    = 72;
    localparam int POT_W    = ACC_W - 16;
    localparam int RES_W    = 58;
    localparam int DIV_W    = 48;
    localparam int DIVS_W   = 32;
    localparam int DIV_CNT_W = $clog2(DIV_W + 1);
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_P_GAIN     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_I_GAIN     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_D_GAIN     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_INPUT_MIN  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_INPUT_MAX  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_MIN = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_MAX = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_CONTINUOUS = 3'd7;

    typedef enum logic [1:0] {
        KIND_TICK    = 2'd0,
        KIND_ENABLE  = 2'd1,
        KIND_DISABLE = 2'd2,
        KIND_RESET   = 2'd3
    } kind_t;

    // multiply pass: which operand and gain
    typedef enum logic [1:0] {
        PH_CAND_I = 2'd0,
        PH_ERR_P  = 2'd1,
        PH_SUM_I  = 2'd2,
        PH_DIFF_D = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        DSEL_INTEG = 2'd0,
        DSEL_LEFT  = 2'd1,
        DSEL_RIGHT = 2'd2
    } div_sel_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_ERR1,
        ST_ERR2,
        ST_CAND,
        ST_MLOAD,
        ST_MLO,
        ST_MHI,
        ST_MACC,
        ST_MDONE,
        ST_IDIV,
        ST_IWAIT,
        ST_CLAMP,
        ST_LDIV,
        ST_LWAIT,
        ST_RDIV,
        ST_RWAIT,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic     load_in;
        logic     calc_err1;
        logic     calc_err2;
        logic     calc_cand;
        logic     mul_load;
        logic     mul_lo;
        logic     mul_hi;
        logic     mul_acc;
        logic     isum_cand;
        logic     isum_zero;
        logic     res_add;
        logic     clamp_out;
        logic     div_start;
        div_sel_t div_sel;
        logic     wb_isum;
        logic     wb_left;
        logic     wb_right;
        logic     clear_out;
        logic     clear_state;
        phase_t   phase;
    } pdc_cmd_t;

    typedef struct packed {
        logic in_range;
        logic igain_zero;
        logic div_busy;
    } pdc_status_t;

endpackage

[design/pdc_divider.sv]
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on pdc_pkg for its widths.
module pdc_divider (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [pdc_pkg::DIV_W-1:0]  dividend,
    input  logic [pdc_pkg::DIVS_W-1:0] divisor,
    output logic [pdc_pkg::DIV_W-1:0]  quotient,
    output logic                       busy
);
    import pdc_pkg::*;

    logic [DIV_W-1:0]     quo_reg;
    logic [DIVS_W-1:0]    rem_reg;
    logic [DIVS_W-1:0]    dvs_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 busy_reg;
    logic [DIVS_W:0]      rem_sh;
    logic [DIVS_W:0]      trial;

    assign rem_sh = {rem_reg, quo_reg[DIV_W-1]};
    assign trial  = rem_sh - {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= DIV_CNT_W'(DIV_W);
        end
        else if (busy_reg) begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == DIV_CNT_W'(1)) begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk) begin
        if (start) begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg) begin
            if (!trial[DIVS_W]) begin
                rem_reg <= trial[DIVS_W-1:0];
                quo_reg <= {quo_reg[DIV_W-2:0], 1'b1};
            end
            else begin
                rem_reg <= rem_sh[DIVS_W-1:0];
                quo_reg <= {quo_reg[DIV_W-2:0], 1'b0};
            end
        end
    end

    assign quotient = quo_reg;
    assign busy     = busy_reg;

endmodule

[design/pdc_datapath.sv]
// Datapath: configuration registers, loop state, shared multiplier,
// accumulators and the divider. Depends on pdc_pkg and pdc_divider.
module pdc_datapath (
    input  logic                            clk,
    input  logic                            rst_n,
    input  pdc_pkg::pdc_cmd_t               cmd,
    output pdc_pkg::pdc_status_t            status,
    input  logic                            cfg_we,
    input  logic [pdc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [pdc_pkg::DATA_W-1:0]      cfg_data,
    input  logic [pdc_pkg::DATA_W-1:0]      in_left,
    input  logic [pdc_pkg::DATA_W-1:0]      in_right,
    input  logic [pdc_pkg::DATA_W-1:0]      in_target,
    output logic [pdc_pkg::DATA_W-1:0]      left_drive,
    output logic [pdc_pkg::DATA_W-1:0]      right_drive,
    output logic [pdc_pkg::DATA_W-1:0]      pid_output,
    output logic [pdc_pkg::DATA_W-1:0]      error_value,
    output logic [1:0]                      divide_fault
);
    import pdc_pkg::*;

    localparam logic signed [DATA_W-1:0] S32_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W-1:0] S32_MIN = {1'b1, {(DATA_W-1){1'b0}}};
    localparam logic signed [SUM_W-1:0]  S48_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0]  S48_MIN = {1'b1, {(SUM_W-1){1'b0}}};

    // configuration
    logic signed [GAIN_W-1:0] p_gain_reg, i_gain_reg, d_gain_reg;
    logic signed [DATA_W-1:0] in_min_reg, in_max_reg, out_min_reg, out_max_reg;
    logic                     cont_reg;

    // loop state and work registers
    logic signed [DATA_W-1:0] prev_reg;
    logic signed [SUM_W-1:0]  isum_reg;
    logic signed [SUM_W-1:0]  cand_reg;
    logic signed [DATA_W-1:0] left_pos_reg, right_pos_reg, target_reg;
    logic signed [DATA_W:0]   err0_reg, range_reg;
    logic signed [DATA_W-1:0] err_reg;
    logic signed [SUM_W-1:0]  qa_reg;
    logic signed [GAIN_W-1:0] qg_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [RES_W-1:0]  res_reg;
    logic signed [DATA_W-1:0] pid_reg, ldrv_reg, rdrv_reg;
    logic [1:0]               fault_reg;

    // combinational terms
    logic signed [DATA_W-1:0] sp;
    logic signed [DATA_W:0]   pos_sum;
    logic signed [DATA_W-1:0] mean;
    logic signed [DATA_W+1:0] err_abs, wrapped;
    logic signed [DATA_W+2:0] err_twice;
    logic signed [DATA_W-1:0] err_sat;
    logic signed [SUM_W:0]    cand_sum;
    logic signed [SUM_W-1:0]  cand_sat;
    logic signed [DATA_W:0]   diff;
    logic signed [SUM_W-1:0]  mul_op;
    logic signed [GAIN_W-1:0] mul_gain;
    logic signed [GAIN_W:0]   lo_op;
    logic signed [PROD_W-1:0] lo_prod, hi_prod;
    logic signed [POT_W-1:0]  pot;
    logic                     pot_hi;
    logic signed [DATA_W-1:0] lim;
    logic signed [DATA_W-1:0] pos_sel;
    logic signed [DIV_W-1:0]  dvd_s;
    logic [DIV_W-1:0]         dvd_mag;
    logic [DIVS_W-1:0]        dvs_mag;
    logic                     q_neg;
    logic [DIV_W-1:0]         quo;
    logic                     div_busy;
    logic signed [SUM_W-1:0]  isum_div;
    logic signed [DATA_W-1:0] drive_val;
    logic signed [DATA_W-1:0] pid_clamped;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            p_gain_reg  <= '0;
            i_gain_reg  <= '0;
            d_gain_reg  <= '0;
            in_min_reg  <= '0;
            in_max_reg  <= '0;
            out_min_reg <= -DATA_W'(65536);
            out_max_reg <= DATA_W'(65536);
            cont_reg    <= 1'b0;
        end
        else if (cfg_we) begin
            case (cfg_index)
                REG_P_GAIN:     p_gain_reg  <= cfg_data[GAIN_W-1:0];
                REG_I_GAIN:     i_gain_reg  <= cfg_data[GAIN_W-1:0];
                REG_D_GAIN:     d_gain_reg  <= cfg_data[GAIN_W-1:0];
                REG_INPUT_MIN:  in_min_reg  <= cfg_data;
                REG_INPUT_MAX:  in_max_reg  <= cfg_data;
                REG_OUTPUT_MIN: out_min_reg <= cfg_data;
                REG_OUTPUT_MAX: out_max_reg <= cfg_data;
                REG_CONTINUOUS: cont_reg    <= cfg_data[0];
                default:        cont_reg    <= cont_reg;
            endcase
        end
    end

    // setpoint clamp and mean of positions
    always_comb begin
        sp = target_reg;
        if (in_max_reg > in_min_reg) begin
            if (target_reg < in_min_reg) begin
                sp = in_min_reg;
            end
            else if (target_reg > in_max_reg) begin
                sp = in_max_reg;
            end
        end
        pos_sum = (DATA_W+1)'(left_pos_reg) + (DATA_W+1)'(right_pos_reg);
        mean    = pos_sum[DATA_W:1];
    end

    // wrap to shortest route and saturate
    always_comb begin
        err_abs   = err0_reg[DATA_W] ? -(DATA_W+2)'(err0_reg) : (DATA_W+2)'(err0_reg);
        err_twice = {err_abs, 1'b0};
        wrapped   = (DATA_W+2)'(err0_reg);
        if (cont_reg && (err_twice > (DATA_W+3)'(range_reg))) begin
            if (err0_reg > 0) begin
                wrapped = (DATA_W+2)'(err0_reg) - (DATA_W+2)'(range_reg);
            end
            else begin
                wrapped = (DATA_W+2)'(err0_reg) + (DATA_W+2)'(range_reg);
            end
        end
        if (wrapped > (DATA_W+2)'(S32_MAX)) begin
            err_sat = S32_MAX;
        end
        else if (wrapped < (DATA_W+2)'(S32_MIN)) begin
            err_sat = S32_MIN;
        end
        else begin
            err_sat = wrapped[DATA_W-1:0];
        end
    end

    always_comb begin
        cand_sum = (SUM_W+1)'(isum_reg) + (SUM_W+1)'(err_reg);
        if (cand_sum > (SUM_W+1)'(S48_MAX)) begin
            cand_sat = S48_MAX;
        end
        else if (cand_sum < (SUM_W+1)'(S48_MIN)) begin
            cand_sat = S48_MIN;
        end
        else begin
            cand_sat = cand_sum[SUM_W-1:0];
        end
    end

    // operand and gain of each multiply pass
    always_comb begin
        diff = (DATA_W+1)'(err_reg) - (DATA_W+1)'(prev_reg);
        case (cmd.phase)
            PH_CAND_I: begin
                mul_op   = cand_reg;
                mul_gain = i_gain_reg;
            end
            PH_ERR_P: begin
                mul_op   = SUM_W'(err_reg);
                mul_gain = p_gain_reg;
            end
            PH_SUM_I: begin
                mul_op   = isum_reg;
                mul_gain = i_gain_reg;
            end
            default: begin
                mul_op   = SUM_W'(diff);
                mul_gain = d_gain_reg;
            end
        endcase
        lo_op   = $signed({1'b0, qa_reg[GAIN_W-1:0]});
        lo_prod = lo_op * qg_reg;
        hi_prod = $signed(qa_reg[SUM_W-1:GAIN_W]) * qg_reg;
        pot     = acc_reg[ACC_W-1:16];
        pot_hi  = pot >= POT_W'(out_max_reg);
    end

    assign status.in_range   = (pot < POT_W'(out_max_reg)) && (pot > POT_W'(out_min_reg));
    assign status.igain_zero = (i_gain_reg == '0);
    assign status.div_busy   = div_busy;

    // divider operands as magnitudes, sign applied on writeback
    always_comb begin
        lim     = pot_hi ? out_max_reg : out_min_reg;
        pos_sel = (cmd.div_sel == DSEL_RIGHT) ? right_pos_reg : left_pos_reg;
        if (cmd.div_sel == DSEL_INTEG) begin
            dvd_s   = {lim, 16'b0};
            dvs_mag = DIVS_W'(i_gain_reg[GAIN_W-1] ? -i_gain_reg : i_gain_reg);
            dvs_mag[DIVS_W-1:GAIN_W] = '0;
            q_neg   = lim[DATA_W-1] ^ i_gain_reg[GAIN_W-1];
        end
        else begin
            dvd_s   = {pid_reg, 16'b0};
            dvs_mag = pos_sel[DATA_W-1] ? -pos_sel : pos_sel;
            q_neg   = pid_reg[DATA_W-1] ^ pos_sel[DATA_W-1];
        end
        dvd_mag = dvd_s[DIV_W-1] ? -dvd_s : dvd_s;
    end

    pdc_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (dvd_mag),
        .divisor  (dvs_mag),
        .quotient (quo),
        .busy     (div_busy)
    );

    always_comb begin
        if (q_neg) begin
            isum_div = -$signed(quo);
        end
        else if (quo[DIV_W-1]) begin
            isum_div = S48_MAX;
        end
        else begin
            isum_div = $signed(quo);
        end

        if (pos_sel == '0) begin
            if (pid_reg > 0) begin
                drive_val = S32_MAX;
            end
            else if (pid_reg < 0) begin
                drive_val = S32_MIN;
            end
            else begin
                drive_val = '0;
            end
        end
        else if (!q_neg) begin
            drive_val = (quo[DIV_W-1:DATA_W-1] != '0) ? S32_MAX : $signed(quo[DATA_W-1:0]);
        end
        else if ((quo[DIV_W-1:DATA_W] != '0) ||
                 (quo[DATA_W-1] && (quo[DATA_W-2:0] != '0))) begin
            drive_val = S32_MIN;
        end
        else begin
            drive_val = -$signed(quo[DATA_W-1:0]);
        end

        if (res_reg > RES_W'(out_max_reg)) begin
            pid_clamped = out_max_reg;
        end
        else if (res_reg < RES_W'(out_min_reg)) begin
            pid_clamped = out_min_reg;
        end
        else begin
            pid_clamped = res_reg[DATA_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            prev_reg <= '0;
            isum_reg <= '0;
        end
        else if (cmd.clear_state) begin
            prev_reg <= '0;
            isum_reg <= '0;
        end
        else begin
            if (cmd.isum_cand) begin
                isum_reg <= cand_reg;
            end
            if (cmd.isum_zero) begin
                isum_reg <= '0;
            end
            if (cmd.wb_isum) begin
                isum_reg <= isum_div;
            end
            if (cmd.clamp_out) begin
                prev_reg <= err_reg;
            end
        end
    end

    always_ff @(posedge clk) begin
        if (cmd.load_in) begin
            left_pos_reg  <= in_left;
            right_pos_reg <= in_right;
            target_reg    <= in_target;
            res_reg       <= '0;
        end
        if (cmd.calc_err1) begin
            err0_reg  <= (DATA_W+1)'(sp) - (DATA_W+1)'(mean);
            range_reg <= (DATA_W+1)'(in_max_reg) - (DATA_W+1)'(in_min_reg);
        end
        if (cmd.calc_err2) begin
            err_reg <= err_sat;
        end
        if (cmd.calc_cand) begin
            cand_reg <= cand_sat;
        end
        if (cmd.mul_load) begin
            qa_reg  <= mul_op;
            qg_reg  <= mul_gain;
            acc_reg <= '0;
        end
        if (cmd.mul_lo) begin
            prod_reg <= lo_prod;
        end
        if (cmd.mul_hi) begin
            acc_reg  <= acc_reg + ACC_W'(prod_reg);
            prod_reg <= hi_prod;
        end
        if (cmd.mul_acc) begin
            acc_reg <= acc_reg + (ACC_W'(prod_reg) <<< GAIN_W);
        end
        if (cmd.res_add) begin
            res_reg <= res_reg + RES_W'(pot);
        end
        if (cmd.clamp_out) begin
            pid_reg   <= pid_clamped;
            fault_reg <= 2'b00;
        end
        if (cmd.wb_left) begin
            ldrv_reg     <= drive_val;
            fault_reg[0] <= (pos_sel == '0);
        end
        if (cmd.wb_right) begin
            rdrv_reg     <= drive_val;
            fault_reg[1] <= (pos_sel == '0);
        end
        if (cmd.clear_out) begin
            ldrv_reg  <= '0;
            rdrv_reg  <= '0;
            pid_reg   <= '0;
            err_reg   <= '0;
            fault_reg <= 2'b00;
        end
    end

    assign left_drive   = ldrv_reg;
    assign right_drive  = rdrv_reg;
    assign pid_output   = pid_reg;
    assign error_value  = err_reg;
    assign divide_fault = fault_reg;

endmodule

[design/pdc_controller.sv]
// Sequencer for the PID drive controller: steps the datapath through one item.
// Depends on pdc_pkg for the state, command and status types.
module pdc_controller (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [1:0]           in_kind,
    output logic                 out_valid,
    input  logic                 out_ready,
    input  pdc_pkg::pdc_status_t status,
    output pdc_pkg::pdc_cmd_t    cmd
);
    import pdc_pkg::*;

    state_t state_reg, state_next;
    phase_t phase_reg, phase_next;
    logic   running_reg, running_next;
    logic   accept;
    kind_t  kind;

    assign accept = in_valid && (state_reg == ST_IDLE);
    assign kind   = kind_t'(in_kind);

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg   <= ST_IDLE;
            phase_reg   <= PH_CAND_I;
            running_reg <= 1'b0;
        end
        else begin
            state_reg   <= state_next;
            phase_reg   <= phase_next;
            running_reg <= running_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        phase_next   = phase_reg;
        running_next = running_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    case (kind)
                        KIND_ENABLE: running_next = 1'b1;
                        KIND_DISABLE, KIND_RESET: begin
                            running_next = 1'b0;
                            state_next   = ST_OUT;
                        end
                        default: begin
                            if (running_reg) begin
                                state_next = ST_ERR1;
                            end
                        end
                    endcase
                end
            end
            ST_ERR1:  state_next = ST_ERR2;
            ST_ERR2:  state_next = ST_CAND;
            ST_CAND: begin
                phase_next = PH_CAND_I;
                state_next = ST_MLOAD;
            end
            ST_MLOAD: state_next = ST_MLO;
            ST_MLO:   state_next = ST_MHI;
            ST_MHI:   state_next = ST_MACC;
            ST_MACC:  state_next = ST_MDONE;
            ST_MDONE: begin
                if (phase_reg == PH_CAND_I) begin
                    if (status.in_range || status.igain_zero) begin
                        phase_next = PH_ERR_P;
                        state_next = ST_MLOAD;
                    end
                    else begin
                        state_next = ST_IDIV;
                    end
                end
                else if (phase_reg == PH_DIFF_D) begin
                    state_next = ST_CLAMP;
                end
                else begin
                    phase_next = phase_t'(phase_reg + 2'd1);
                    state_next = ST_MLOAD;
                end
            end
            ST_IDIV:  state_next = ST_IWAIT;
            ST_IWAIT: begin
                if (!status.div_busy) begin
                    phase_next = PH_ERR_P;
                    state_next = ST_MLOAD;
                end
            end
            ST_CLAMP: state_next = ST_LDIV;
            ST_LDIV:  state_next = ST_LWAIT;
            ST_LWAIT: begin
                if (!status.div_busy) begin
                    state_next = ST_RDIV;
                end
            end
            ST_RDIV:  state_next = ST_RWAIT;
            ST_RWAIT: begin
                if (!status.div_busy) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (out_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd       = '0;
        cmd.phase = phase_reg;
        in_ready  = (state_reg == ST_IDLE);
        out_valid = (state_reg == ST_OUT);
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    cmd.load_in     = 1'b1;
                    cmd.clear_out   = (kind == KIND_DISABLE) || (kind == KIND_RESET);
                    cmd.clear_state = (kind == KIND_RESET);
                end
            end
            ST_ERR1:  cmd.calc_err1 = 1'b1;
            ST_ERR2:  cmd.calc_err2 = 1'b1;
            ST_CAND:  cmd.calc_cand = 1'b1;
            ST_MLOAD: cmd.mul_load  = 1'b1;
            ST_MLO:   cmd.mul_lo    = 1'b1;
            ST_MHI:   cmd.mul_hi    = 1'b1;
            ST_MACC:  cmd.mul_acc   = 1'b1;
            ST_MDONE: begin
                if (phase_reg == PH_CAND_I) begin
                    cmd.isum_cand = status.in_range;
                    cmd.isum_zero = !status.in_range && status.igain_zero;
                end
                else begin
                    cmd.res_add = 1'b1;
                end
            end
            ST_IDIV: begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DSEL_INTEG;
            end
            ST_IWAIT: begin
                cmd.div_sel = DSEL_INTEG;
                cmd.wb_isum = !status.div_busy;
            end
            ST_CLAMP: cmd.clamp_out = 1'b1;
            ST_LDIV: begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DSEL_LEFT;
            end
            ST_LWAIT: begin
                cmd.div_sel = DSEL_LEFT;
                cmd.wb_left = !status.div_busy;
            end
            ST_RDIV: begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DSEL_RIGHT;
            end
            ST_RWAIT: begin
                cmd.div_sel  = DSEL_RIGHT;
                cmd.wb_right = !status.div_busy;
            end
            default: cmd.phase = phase_reg;
        endcase
    end

endmodule

[design/pid_drive_controller.sv]
// Top level of the PID drive controller: ports, controller and datapath.
// Depends on pdc_pkg, pdc_controller and pdc_datapath.
//
// Usage:
//   s_axis carries one event per transfer: tuser holds the kind (control tick,
//   enable, disable, reset); tdata holds left position, right position and
//   target, all signed Q16.16. m_axis carries one result per tick while
//   running and one all-zero result per disable or reset; enable and ticks
//   while disabled give no result. cfg writes one register per transfer
//   (index 0..7 as p_gain, i_gain, d_gain, input_min, input_max, output_min,
//   output_max, continuous_mode); write only while the block is idle.
// Timing:
//   One item is worked at a time. A tick works through three error and
//   candidate steps, four two-pass multiplies on the shared 25x24
//   multiplier, the output clamp, and two divisions on the single restoring
//   divider (48 quotient bits each), or three divisions when the integral is
//   clamped with a nonzero integral gain. Enable and a tick while disabled
//   free the input the next cycle; disable and reset show their result in
//   the cycle after the transfer. The next item is taken once the result is
//   gone.
// Reset and stall:
//   rst_n clears the loop state, the running flag and the configuration registers
//   to their defaults, not the work and output registers. A stalled receiver holds
//   the result in the output registers and s_axis_tready stays low until that transfer completes.
module pid_drive_controller (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [95:0]                   s_axis_tdata,  // left_position, right_position, target
    input  logic [1:0]                    s_axis_tuser,  // kind
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [127:0]                  m_axis_tdata,  // left_drive, right_drive, pid_output, error_value
    output logic [1:0]                    m_axis_tuser,  // divide_fault
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [pdc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [pdc_pkg::DATA_W-1:0]    cfg_data
);
    import pdc_pkg::*;

    pdc_cmd_t    cmd;
    pdc_status_t status;
    logic [DATA_W-1:0] left_drive, right_drive, pid_output, error_value;
    logic [1:0]        divide_fault;

    // configuration is always accepted and lands in the next cycle
    assign cfg_ready = 1'b1;

    pdc_controller u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_kind   (s_axis_tuser),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .status    (status),
        .cmd       (cmd)
    );

    pdc_datapath u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .cfg_we       (cfg_valid),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_left      (s_axis_tdata[31:0]),
        .in_right     (s_axis_tdata[63:32]),
        .in_target    (s_axis_tdata[95:64]),
        .left_drive   (left_drive),
        .right_drive  (right_drive),
        .pid_output   (pid_output),
        .error_value  (error_value),
        .divide_fault (divide_fault)
    );

    assign m_axis_tdata = {error_value, pid_output, right_drive, left_drive};
    assign m_axis_tuser = divide_fault;

endmodule

[tb/pid_drive_controller_tb.sv]
// Self-checking testbench for pid_drive_controller: drives events on s_axis,
// predicts every m_axis result with its own fixed-point loop model and checks them.
// Depends on pdc_pkg and the pid_drive_controller RTL.
`timescale 1ns / 100ps

module pid_drive_controller_tb;
    import pdc_pkg::*;

    localparam longint SUM_HI = 64'sd140737488355327;
    localparam longint SUM_LO = -SUM_HI - 1;
    localparam longint I32_HI = 64'sd2147483647;
    localparam longint I32_LO = -64'sd2147483648;
    localparam int     IDLE_LIMIT = 4000;

    typedef struct packed {
        logic [1:0]  fault;
        logic [31:0] err;
        logic [31:0] pid;
        logic [31:0] rdrive;
        logic [31:0] ldrive;
    } drive_result_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [95:0]  s_axis_tdata = '0;
    logic [1:0]   s_axis_tuser = KIND_TICK;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [127:0] m_axis_tdata;
    logic [1:0]   m_axis_tuser;
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = REG_P_GAIN;
    logic [DATA_W-1:0]    cfg_data = '0;

    // loop model: registers and state
    longint kp, ki, kd, in_lo, in_hi, out_lo, out_hi;
    bit     wrap_on;
    longint last_err, isum;
    bit     loop_on;

    drive_result_t expected_q[$];
    int  failures = 0;
    int  idle_cycles = 0;
    bit  rx_quiet = 1'b0;   // receiver throttling off
    bit  tx_quiet = 1'b0;
    int  rx_hold = 0;       // long receiver hold-off, counted in cycles

    always #6 clk = ~clk;

    pid_drive_controller i_dut (.*);

    // floor(a * g / 2^16), split so that no product overflows 64 bits
    function automatic longint gain_mul(longint a, longint g);
        longint hi, lo;
        hi = a >>> 24;
        lo = a - hi * 64'sd16777216;
        return hi * g * 256 + ((lo * g) >>> 16);
    endfunction

    function automatic longint clip(longint x, longint lo, longint hi);
        return x < lo ? lo : (x > hi ? hi : x);
    endfunction

    // a zero position saturates by the sign of the loop output
    function automatic longint side_drive(longint pid, longint pos);
        if (pos == 0) begin
            return pid > 0 ? I32_HI : (pid < 0 ? I32_LO : 64'sd0);
        end
        return clip((pid * 65536) / pos, I32_LO, I32_HI);
    endfunction

    // advance the loop model by one event; push the result it causes
    task automatic predict_event(kind_t k, logic [95:0] d);
        longint lp, rp, sp, e, span, cand, pot, res;
        drive_result_t r;
        r = '0;
        if (k == KIND_ENABLE) begin
            loop_on = 1'b1;
            return;
        end
        if (k != KIND_TICK) begin
            loop_on = 1'b0;
            if (k == KIND_RESET) begin
                last_err = 0;
                isum = 0;
            end
            expected_q.push_back(r);
            return;
        end
        if (!loop_on) return;
        lp = longint'($signed(d[31:0]));
        rp = longint'($signed(d[63:32]));
        sp = longint'($signed(d[95:64]));
        if (in_hi > in_lo) sp = clip(sp, in_lo, in_hi);
        e = sp - ((lp + rp) >>> 1);
        if (wrap_on) begin
            span = in_hi - in_lo;
            if (2 * (e < 0 ? -e : e) > span) e = (e > 0) ? e - span : e + span;
        end
        e = clip(e, I32_LO, I32_HI);
        cand = clip(isum + e, SUM_LO, SUM_HI);
        pot = gain_mul(cand, ki);
        if (pot < out_hi && pot > out_lo) isum = cand;
        else if (ki == 0) isum = 0;
        else if (pot >= out_hi) isum = clip((out_hi * 65536) / ki, SUM_LO, SUM_HI);
        else isum = clip((out_lo * 65536) / ki, SUM_LO, SUM_HI);
        res = gain_mul(e, kp) + gain_mul(isum, ki) + gain_mul(e - last_err, kd);
        last_err = e;
        if (res > out_hi) res = out_hi;
        else if (res < out_lo) res = out_lo;
        r.ldrive   = 32'(side_drive(res, lp));
        r.rdrive   = 32'(side_drive(res, rp));
        r.fault[0] = (lp == 0);
        r.fault[1] = (rp == 0);
        r.pid      = 32'(res);
        r.err      = 32'(e);
        expected_q.push_back(r);
    endtask

    // send one event; hold tvalid across back-to-back transfers
    task automatic send_event(kind_t k, logic [31:0] lp, logic [31:0] rp, logic [31:0] tg);
        while (!tx_quiet && $urandom_range(99) < 24) begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= k;
        s_axis_tdata  <= {tg, rp, lp};
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        predict_event(k, {tg, rp, lp});
    endtask

    task automatic release_input();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
    endtask

    // wait until every expected result has arrived and the block is quiet
    task automatic drain();
        release_input();
        while (expected_q.size() != 0) @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    // hold cfg_valid high; the caller drops it after the last write
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        case (idx)
            REG_P_GAIN:     kp = longint'($signed(val[23:0]));
            REG_I_GAIN:     ki = longint'($signed(val[23:0]));
            REG_D_GAIN:     kd = longint'($signed(val[23:0]));
            REG_INPUT_MIN:  in_lo = longint'($signed(val));
            REG_INPUT_MAX:  in_hi = longint'($signed(val));
            REG_OUTPUT_MIN: out_lo = longint'($signed(val));
            REG_OUTPUT_MAX: out_hi = longint'($signed(val));
            default:        wrap_on = val[0];
        endcase
    endtask

    task automatic load_settings(logic [31:0] p, logic [31:0] i, logic [31:0] d,
                                 logic [31:0] ilo, logic [31:0] ihi,
                                 logic [31:0] olo, logic [31:0] ohi, bit wr);
        write_reg(REG_P_GAIN, p);
        write_reg(REG_I_GAIN, i);
        write_reg(REG_D_GAIN, d);
        write_reg(REG_INPUT_MIN, ilo);
        write_reg(REG_INPUT_MAX, ihi);
        write_reg(REG_OUTPUT_MIN, olo);
        write_reg(REG_OUTPUT_MAX, ohi);
        write_reg(REG_CONTINUOUS, {31'd0, wr});
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // positions mostly near the origin, sometimes extreme or zero
    function automatic logic [31:0] rand_pos();
        case ($urandom_range(9))
            0:       return 32'h0;
            1:       return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            2, 3:    return $urandom;
            default: return 32'($signed($urandom_range(20 * 65536)) - 10 * 65536);
        endcase
    endfunction

    // extreme fields, every kind, zero positions, ticks while disabled
    task automatic test_directed();
        load_settings(32'h01_0000, 32'h00_4000, 32'h00_8000, 32'hFFFB_0000, 32'h0005_0000,
                      32'hFFFF_0000, 32'h0001_0000, 1'b0);
        send_event(KIND_TICK, 32'h1_0000, 32'h1_0000, 32'h2_0000);
        send_event(KIND_ENABLE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_event(KIND_TICK, 32'h1_0000, 32'h3_0000, 32'h4_0000);
        send_event(KIND_TICK, 32'h0, 32'h2_0000, 32'h1_0000);
        send_event(KIND_TICK, 32'h2_0000, 32'h0, 32'hFFFF_0000);
        send_event(KIND_TICK, 32'h0, 32'h0, 32'h0);
        send_event(KIND_TICK, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
        send_event(KIND_TICK, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF);
        send_event(KIND_TICK, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        send_event(KIND_TICK, 32'h1, 32'hFFFF_FFFF, 32'h0);
        send_event(KIND_DISABLE, 32'h0, 32'h0, 32'h0);
        send_event(KIND_TICK, 32'h1_0000, 32'h1_0000, 32'h1_0000);
        send_event(KIND_ENABLE, 32'h0, 32'h0, 32'h0);
        send_event(KIND_TICK, 32'h5_0000, 32'h5_0000, 32'h7FFF_FFFF);
        send_event(KIND_RESET, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF);
        send_event(KIND_TICK, 32'h1_0000, 32'h1_0000, 32'h1_0000);
        send_event(KIND_ENABLE, 32'h0, 32'h0, 32'h0);
        send_event(KIND_TICK, 32'hFFFF_0000, 32'h1_0000, 32'h0);
        drain();
    endtask

    // run random events under one register setting
    task automatic run_phase(int count);
        kind_t k;
        send_event(KIND_ENABLE, rand_pos(), rand_pos(), rand_pos());
        repeat (count) begin
            case ($urandom_range(39))
                0:       k = KIND_ENABLE;
                1:       k = KIND_DISABLE;
                2:       k = KIND_RESET;
                default: k = KIND_TICK;
            endcase
            send_event(k, rand_pos(), rand_pos(), $urandom_range(3) == 0 ? $urandom : rand_pos());
            if (k == KIND_DISABLE || k == KIND_RESET)
                send_event(KIND_ENABLE, rand_pos(), rand_pos(), rand_pos());
        end
        drain();
    endtask

    // sweep register settings, extremes included
    task automatic test_settings_sweep();
        load_settings(32'h7F_FFFF, 32'h80_0000, 32'h7F_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                      32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
        run_phase(100);
        load_settings(32'h80_0000, 32'h7F_FFFF, 32'h80_0000, 32'hFFF6_0000, 32'h000A_0000,
                      32'hFFFE_0000, 32'h0003_0000, 1'b1);
        run_phase(100);
        // continuous wrap with a crossed input range, and zero integral gain
        load_settings(32'h00_8000, 32'h0, 32'h00_1000, 32'h0005_0000, 32'hFFFB_0000,
                      32'hFFFF_0000, 32'h0001_0000, 1'b1);
        run_phase(80);
        // crossed output limits
        load_settings(32'h01_0000, 32'h00_0100, 32'h0, 32'h0, 32'h0,
                      32'h0002_0000, 32'hFFFE_0000, 1'b0);
        run_phase(60);
        repeat (4) begin
            load_settings($urandom, $urandom, $urandom, $urandom, $urandom,
                          $urandom, $urandom, $urandom_range(1));
            run_phase(80);
        end
    endtask

    // long run with no idling, then a receiver hold-off so the input stalls
    task automatic test_backpressure();
        load_settings(32'h00_C000, 32'h00_0800, 32'h00_2000, 32'hFFE0_0000, 32'h0020_0000,
                      32'hFFF0_0000, 32'h0010_0000, 1'b0);
        tx_quiet = 1'b1;
        rx_quiet = 1'b1;
        run_phase(60);
        rx_hold = 400;
        tx_quiet = 1'b0;
        rx_quiet = 1'b0;
        run_phase(60);
    endtask

    // receiver: random stalls, plus the hold-off counted here
    always @(posedge clk) begin
        if (rx_hold > 0) begin
            rx_hold <= rx_hold - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= rx_quiet || ($urandom_range(99) >= 24);
        end
    end

    // check each result transfer against the oldest expectation
    always @(posedge clk) begin
        drive_result_t got, exp_r;
        if (rst_n && m_axis_tvalid && m_axis_tready) begin
            got = {m_axis_tuser, m_axis_tdata};
            if (expected_q.size() == 0) begin
                $error("unexpected result transfer");
                failures++;
            end else begin
                exp_r = expected_q.pop_front();
                if (got.ldrive !== exp_r.ldrive) begin
                    $error("left_drive exp %h got %h", exp_r.ldrive, got.ldrive);
                    failures++;
                end
                if (got.rdrive !== exp_r.rdrive) begin
                    $error("right_drive exp %h got %h", exp_r.rdrive, got.rdrive);
                    failures++;
                end
                if (got.pid !== exp_r.pid) begin
                    $error("pid_output exp %h got %h", exp_r.pid, got.pid);
                    failures++;
                end
                if (got.err !== exp_r.err) begin
                    $error("error_value exp %h got %h", exp_r.err, got.err);
                    failures++;
                end
                if (got.fault !== exp_r.fault) begin
                    $error("divide_fault exp %h got %h", exp_r.fault, got.fault);
                    failures++;
                end
            end
        end
    end

    // watchdog: count cycles with no transfer on any channel
    always @(posedge clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > IDLE_LIMIT) begin
            $display("** pid_drive_controller: FAILED **");
            $finish;
        end
    end

    initial begin
        kp = 0; ki = 0; kd = 0; in_lo = 0; in_hi = 0;
        out_lo = -65536; out_hi = 65536; wrap_on = 1'b0;
        last_err = 0; isum = 0; loop_on = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_settings_sweep();
        test_backpressure();
        if (failures == 0 && expected_q.size() == 0)
            $display("** pid_drive_controller: PASSED **");
        else
            $display("** pid_drive_controller: FAILED **");
        $finish;
    end

endmodule
